[hdl/mroe_pkg.sv]
// Package for the matrix row-operation engine: command and result types,
// command, status and state codes, and the shared saturation helper.
// No dependencies.
`default_nettype none

package mroe_pkg;

  localparam int DATA_W     = 32;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Reset value of both dimension registers.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [63:0] CELL_MAX = 64'sd2147483647;
  localparam logic signed [63:0] CELL_MIN = -64'sd2147483648;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_SWAP  = 3'd2,
    KIND_ADD   = 3'd3,
    KIND_SCALE = 3'd4,
    KIND_SORT  = 3'd5,
    KIND_NORM  = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_ROW = 2'd1,
    STATUS_SAT      = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_SW_RD_A,
    ST_SW_RD_B,
    ST_SW_WR_A,
    ST_SW_WR_B,
    ST_MA_RD_SRC,
    ST_MA_MUL,
    ST_MA_WB,
    ST_SO_NEXT,
    ST_SO_CHECK,
    ST_SO_RD_PREV,
    ST_SO_CMP,
    ST_NL_SCAN,
    ST_NL_TEST,
    ST_NL_RD,
    ST_NL_START,
    ST_NL_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         row_a;
    logic [IDX_W-1:0]         row_b;
    logic [IDX_W-1:0]         column;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
  } res_t;

  // Saturate a wide signed value to a cell; the top bit flags saturation.
  function automatic logic [DATA_W:0] clip_cell(input logic signed [63:0] v);
    logic [DATA_W:0] r;
    if (v > CELL_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < CELL_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/mroe_store.sv]
// Matrix cell store: one write port, one registered read port, and a valid
// bit per cell so that unwritten cells read as row times column.
// Depends on mroe_pkg.
`default_nettype none

module mroe_store
  import mroe_pkg::*;
#(
  parameter int MAX_ROWS      = 8,
  parameter int MAX_COLS      = 8,
  parameter int FRACTION_BITS = 16,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [RW-1:0]     wr_row_i,
  input  logic [CW-1:0]     wr_col_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [RW-1:0]     rd_row_i,
  input  logic [CW-1:0]     rd_col_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_mem_q;
  logic              rd_valid_q;
  logic [RW-1:0]     rd_row_q;
  logic [CW-1:0]     rd_col_q;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Reset content of a cell: row times column in fixed point, saturated.
  function automatic logic [DATA_W-1:0] reset_cell(input logic [RW-1:0] r,
                                                   input logic [CW-1:0] c);
    logic [RW+CW-1:0] prod;
    logic [63:0]      v;
    prod = (RW+CW)'(r) * (RW+CW)'(c);
    v    = 64'(prod) << FRACTION_BITS;
    return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[DATA_W-1:0];
  endfunction

  assign wr_addr = ADDR_W'(wr_row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(wr_col_i);
  assign rd_addr = ADDR_W'(rd_row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col_i);

  // Cell array and its read register.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    rd_mem_q <= mem_q[rd_addr];
    rd_row_q <= rd_row_i;
    rd_col_q <= rd_col_i;
  end

  // Written flags, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr];
      if (wr_en_i) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_mem_q : reset_cell(rd_row_q, rd_col_q);

endmodule

`default_nettype wire

[hdl/mroe_div.sv]
// Serial restoring divider for row normalization: (x << FRACTION_BITS) / d,
// truncated toward zero and saturated to a cell, one quotient bit per cycle.
// Depends on mroe_pkg.
`default_nettype none

module mroe_div
  import mroe_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] dividend_i,
  input  logic signed [DATA_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [DATA_W-1:0]        quot_o,
  output logic                     sat_o
);

  localparam int NUM_W = DATA_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W-1:0] rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DATA_W-1:0] abs_x;
  logic [DATA_W-1:0] abs_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic signed [63:0] qval;
  logic [DATA_W:0]   clipped;

  assign abs_x = dividend_i[DATA_W-1] ? (~dividend_i + 32'd1) : dividend_i;
  assign abs_d = divisor_i[DATA_W-1] ? (~divisor_i + 32'd1) : divisor_i;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = ~diff[DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      dvs_q <= abs_d;
      rem_q <= '0;
      quo_q <= NUM_W'(abs_x) << FRACTION_BITS;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  // Apply the sign and saturate.
  assign qval    = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
  assign clipped = clip_cell(qval);
  assign quot_o  = clipped[DATA_W-1:0];
  assign sat_o   = clipped[DATA_W];
  assign done_o  = done_q;

endmodule

`default_nettype wire

[hdl/matrix_row_operation_engine.sv]
// Matrix row-operation engine: a matrix of signed fixed-point cells with
// write, read, swap, add-scaled-row, scale, stable descending sort on a
// column, and normalize by the leading nonzero entry. One command is taken
// at a time and gives one result; cmd_ready_o is high only while idle, but
// a finished result waits in its own register so the next command can be
// taken before it is collected. A sort makes up to about nr*nr/2 row swaps,
// with nr the rows in use. Multiplies go through one shared registered
// 32x32 multiplier; normalization goes through one serial divider that
// yields one quotient bit per cycle.
// Unwritten cells read as row times column, so no clearing pass is needed.
// Depends on mroe_pkg, mroe_store and mroe_div.
`default_nettype none

module matrix_row_operation_engine
  import mroe_pkg::*;
#(
  parameter int MAX_ROWS      = 8,
  parameter int MAX_COLS      = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam logic [DATA_W-1:0] ONE_FX = 32'd1 << FRACTION_BITS;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] rows_q, cols_q;
  logic [RCW-1:0]        nr, nr_q;
  logic [CCW-1:0]        nc, nc_q;

  logic [KIND_W-1:0]        kind_q;
  logic [IDX_W-1:0]         ra_q, rb_q, col_q;
  logic signed [DATA_W-1:0] val_q;
  logic [CCW-1:0]           c_q;
  logic [RCW-1:0]           i_q, k_q;
  logic [RW-1:0]            swap_x_q, swap_y_q;
  logic [DATA_W-1:0]        tmp_q, piv_q, rd_val_q;
  logic signed [63:0]       prod_q;
  logic                     sat_q, zero_q;
  res_t                     res_q;
  logic                     res_valid_q;

  logic              cmd_fire;
  logic              ra_ok, rb_ok, col_ok, last_col, is_add;
  logic              wr_en;
  logic [RW-1:0]     wr_row, rd_row;
  logic [CW-1:0]     wr_col, rd_col;
  logic [DATA_W-1:0] wr_data, rdata;
  logic [DATA_W:0]   mq, sum;
  logic [DATA_W-1:0] wb_data;
  logic              wb_sat;
  logic              div_start, div_done, div_sat;
  logic [DATA_W-1:0] div_quot;

  // Effective dimensions: zero counts as one, large values are clamped.
  always_comb begin
    if (rows_q == '0) begin
      nr = RCW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_q);
    end
    if (cols_q == '0) begin
      nc = CCW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(cols_q);
    end
  end

  // Configuration registers; the user must write them only while idle, as the block itself does not enforce it.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;

  assign ra_ok    = int'(ra_q) < int'(nr_q);
  assign rb_ok    = int'(rb_q) < int'(nr_q);
  assign col_ok   = int'(col_q) < int'(nc_q);
  assign last_col = (int'(c_q) + 1) >= int'(nc_q);
  assign is_add   = (kind_q == KIND_ADD);

  // Shared multiply path: floor shift, saturate, then optional add.
  assign mq      = clip_cell(prod_q >>> FRACTION_BITS);
  assign sum     = clip_cell(64'($signed(rdata)) + 64'($signed(mq[DATA_W-1:0])));
  assign wb_data = is_add ? sum[DATA_W-1:0] : mq[DATA_W-1:0];
  assign wb_sat  = mq[DATA_W] | (is_add & sum[DATA_W]);

  mroe_store #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (wr_data),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_data_o (rdata)
  );

  mroe_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ($signed(rdata)),
    .divisor_i  ($signed(piv_q)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .sat_o      (div_sat)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and store and divider control.
  always_comb begin
    state_d   = state_q;
    wr_en     = 1'b0;
    wr_row    = RW'(ra_q);
    wr_col    = CW'(c_q);
    wr_data   = wb_data;
    rd_row    = RW'(ra_q);
    rd_col    = CW'(c_q);
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        case (kind_q)
          KIND_WRITE: if (ra_ok && col_ok) state_d = ST_WRITE;
          KIND_READ:  if (ra_ok && col_ok) state_d = ST_READ;
          KIND_SWAP:  if (ra_ok && rb_ok) state_d = ST_SW_RD_A;
          KIND_ADD:   if (ra_ok && rb_ok) state_d = ST_MA_RD_SRC;
          KIND_SCALE: if (ra_ok) state_d = ST_MA_RD_SRC;
          KIND_SORT:  if (col_ok) state_d = ST_SO_NEXT;
          KIND_NORM:  if (ra_ok) state_d = ST_NL_SCAN;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_col  = CW'(col_q);
        wr_data = val_q;
        state_d = ST_DONE;
      end
      ST_READ: begin
        rd_col  = CW'(col_q);
        state_d = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        state_d = ST_DONE;
      end
      ST_SW_RD_A: begin
        rd_row  = swap_x_q;
        state_d = ST_SW_RD_B;
      end
      ST_SW_RD_B: begin
        rd_row  = swap_y_q;
        state_d = ST_SW_WR_A;
      end
      ST_SW_WR_A: begin
        wr_en   = 1'b1;
        wr_row  = swap_x_q;
        wr_data = rdata;
        state_d = ST_SW_WR_B;
      end
      ST_SW_WR_B: begin
        wr_en   = 1'b1;
        wr_row  = swap_y_q;
        wr_data = tmp_q;
        if (!last_col) begin
          state_d = ST_SW_RD_A;
        end else if (kind_q == KIND_SORT) begin
          state_d = ST_SO_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MA_RD_SRC: begin
        rd_row  = is_add ? RW'(rb_q) : RW'(ra_q);
        state_d = ST_MA_MUL;
      end
      ST_MA_MUL: begin
        state_d = ST_MA_WB;
      end
      ST_MA_WB: begin
        wr_en   = 1'b1;
        state_d = last_col ? ST_DONE : ST_MA_RD_SRC;
      end
      ST_SO_NEXT: begin
        state_d = ((int'(i_q) + 1) < int'(nr_q)) ? ST_SO_CHECK : ST_DONE;
      end
      ST_SO_CHECK: begin
        rd_row = RW'(k_q);
        rd_col = CW'(col_q);
        state_d = (k_q == '0) ? ST_SO_NEXT : ST_SO_RD_PREV;
      end
      ST_SO_RD_PREV: begin
        rd_row  = RW'(k_q - 1'b1);
        rd_col  = CW'(col_q);
        state_d = ST_SO_CMP;
      end
      ST_SO_CMP: begin
        state_d = ($signed(tmp_q) > $signed(rdata)) ? ST_SW_RD_A : ST_SO_NEXT;
      end
      ST_NL_SCAN: begin
        state_d = ST_NL_TEST;
      end
      ST_NL_TEST: begin
        if (rdata != '0) begin
          state_d = (rdata == ONE_FX) ? ST_DONE : ST_NL_RD;
        end else begin
          state_d = last_col ? ST_DONE : ST_NL_SCAN;
        end
      end
      ST_NL_RD: begin
        state_d = ST_NL_START;
      end
      ST_NL_START: begin
        div_start = 1'b1;
        state_d   = ST_NL_DIV;
      end
      ST_NL_DIV: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_data = div_quot;
          state_d = last_col ? ST_DONE : ST_NL_RD;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command fields, counters and working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          kind_q   <= cmd_i.kind;
          ra_q     <= cmd_i.row_a;
          rb_q     <= cmd_i.row_b;
          col_q    <= cmd_i.column;
          val_q    <= cmd_i.value;
          nr_q     <= nr;
          nc_q     <= nc;
          rd_val_q <= '0;
          sat_q    <= 1'b0;
          zero_q   <= 1'b0;
        end
      end
      ST_DECODE: begin
        c_q      <= '0;
        i_q      <= '0;
        swap_x_q <= RW'(ra_q);
        swap_y_q <= RW'(rb_q);
      end
      ST_READ_WAIT: begin
        rd_val_q <= rdata;
      end
      ST_SW_RD_B: begin
        tmp_q <= rdata;
      end
      ST_SW_WR_B: begin
        if (!last_col) begin
          c_q <= c_q + 1'b1;
        end else begin
          k_q <= k_q - 1'b1;
        end
      end
      ST_MA_MUL: begin
        prod_q <= $signed(rdata) * val_q;
      end
      ST_MA_WB: begin
        sat_q <= sat_q | wb_sat;
        c_q   <= c_q + 1'b1;
      end
      ST_SO_NEXT: begin
        i_q <= i_q + 1'b1;
        k_q <= i_q + 1'b1;
      end
      ST_SO_RD_PREV: begin
        tmp_q <= rdata;
      end
      ST_SO_CMP: begin
        swap_x_q <= RW'(k_q);
        swap_y_q <= RW'(k_q - 1'b1);
        c_q      <= '0;
      end
      ST_NL_TEST: begin
        if (rdata != '0) begin
          piv_q <= rdata;
        end else if (last_col) begin
          zero_q <= 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      ST_NL_DIV: begin
        if (div_done) begin
          sat_q <= sat_q | div_sat;
          c_q   <= c_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register: holds one finished result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!res_valid_q || res_ready_i)) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!res_valid_q || res_ready_i)) begin
      res_q.read_value <= rd_val_q;
      if (zero_q) begin
        res_q.status <= STATUS_ZERO_ROW;
      end else if (sat_q) begin
        res_q.status <= STATUS_SAT;
      end else begin
        res_q.status <= STATUS_OK;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[test/matrix_row_operation_engine_test.sv]
// Testbench for matrix_row_operation_engine: a directed table followed by random
// command traffic, with results checked against an in-bench matrix model or hand-written values.
// Depends on mroe_pkg and the engine RTL.
`timescale 1ns / 1ps

module matrix_row_operation_engine_test;
  import mroe_pkg::*;

  localparam int NROW = 8;
  localparam int NCOL = 8;
  localparam int FRAC = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  cmd_t                  cmd = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_t                  res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  matrix_row_operation_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Model state of the matrix and the dimension registers.
  logic signed [31:0] cells [NROW*NCOL];
  logic [3:0]         rows_reg;
  logic [3:0]         cols_reg;
  bit                 clipped;
  res_t               pending_res [$];
  int                 mismatches = 0;
  bit                 idle_on = 1'b1;
  int                 ready_hold = 0;

  // Directed rows; typed rows carry an expected result written out by hand.
  typedef struct {
    kind_e              kind;
    logic [2:0]         ra;
    logic [2:0]         rb;
    logic [2:0]         col;
    logic signed [31:0] val;
    bit                 typed;
    logic signed [31:0] exp_rd;
    status_e            exp_st;
  } dir_row_t;

  dir_row_t dir_tab [22] = '{
    '{KIND_READ,  3'd3, 3'd0, 3'd5, 32'sh0,        1'b1, 32'sh000F0000, STATUS_OK},
    '{KIND_READ,  3'd7, 3'd0, 3'd7, 32'sh0,        1'b1, 32'sh00310000, STATUS_OK},
    '{KIND_READ,  3'd0, 3'd0, 3'd0, 32'sh0,        1'b1, 32'sh0,        STATUS_OK},
    '{KIND_NORM,  3'd0, 3'd0, 3'd0, 32'sh0,        1'b1, 32'sh0,        STATUS_ZERO_ROW},
    '{kind_e'(3'd7), 3'd1, 3'd2, 3'd3, 32'sh1234,  1'b1, 32'sh0,        STATUS_OK},
    '{KIND_WRITE, 3'd2, 3'd0, 3'd3, 32'sh7FFFFFFF, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_WRITE, 3'd2, 3'd0, 3'd4, 32'sh80000000, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_READ,  3'd2, 3'd0, 3'd3, 32'sh0,        1'b1, 32'sh7FFFFFFF, STATUS_OK},
    '{KIND_READ,  3'd2, 3'd0, 3'd4, 32'sh0,        1'b1, 32'sh80000000, STATUS_OK},
    '{KIND_SCALE, 3'd7, 3'd0, 3'd0, 32'sh7FFFFFFF, 1'b1, 32'sh0,        STATUS_SAT},
    '{KIND_SWAP,  3'd1, 3'd6, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_ADD,   3'd5, 3'd4, 3'd0, 32'sh00030000, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_ADD,   3'd3, 3'd3, 3'd0, 32'sh00010000, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_NORM,  3'd1, 3'd0, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_NORM,  3'd5, 3'd0, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_SORT,  3'd0, 3'd0, 3'd2, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_SORT,  3'd0, 3'd0, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_WRITE, 3'd4, 3'd0, 3'd0, 32'sh00010000, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_NORM,  3'd4, 3'd0, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_SWAP,  3'd3, 3'd3, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK},
    '{KIND_SCALE, 3'd2, 3'd0, 3'd0, 32'sh80000000, 1'b0, 32'sh0,        STATUS_OK},
    '{KIND_READ,  3'd7, 3'd0, 3'd0, 32'sh0,        1'b0, 32'sh0,        STATUS_OK}
  };

  // Effective dimension: zero counts as one, values above the maximum clamp.
  function automatic int eff_dim(input logic [3:0] v, input int max_v);
    if (v == 4'd0) return 1;
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  function automatic logic signed [31:0] sat_cell(input logic signed [63:0] v);
    if (v > CELL_MAX) begin
      clipped = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < CELL_MIN) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Fixed-point product, floor rounding, saturated.
  function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat_cell(p >>> FRAC);
  endfunction

  function automatic void swap_cells(input int a, input int b, input int nc);
    logic signed [31:0] t;
    for (int c = 0; c < nc; c++) begin
      t = cells[a*NCOL+c];
      cells[a*NCOL+c] = cells[b*NCOL+c];
      cells[b*NCOL+c] = t;
    end
  endfunction

  // Apply one command to the model matrix and return its result.
  function automatic res_t apply_cmd(input cmd_t c);
    res_t               r;
    int                 nr;
    int                 nc;
    int                 ra;
    int                 rb;
    int                 col;
    int                 k;
    int                 lead;
    logic signed [63:0] piv;
    logic signed [63:0] num;
    nr = eff_dim(rows_reg, NROW);
    nc = eff_dim(cols_reg, NCOL);
    ra = c.row_a;
    rb = c.row_b;
    col = c.column;
    r = '0;
    clipped = 1'b0;
    case (c.kind)
      KIND_WRITE: if (ra < nr && col < nc) cells[ra*NCOL+col] = c.value;
      KIND_READ:  if (ra < nr && col < nc) r.read_value = cells[ra*NCOL+col];
      KIND_SWAP:  if (ra < nr && rb < nr) swap_cells(ra, rb, nc);
      KIND_ADD: begin
        if (ra < nr && rb < nr) begin
          for (int i = 0; i < nc; i++) begin
            num = fx_product(cells[rb*NCOL+i], c.value);
            num = num + cells[ra*NCOL+i];
            cells[ra*NCOL+i] = sat_cell(num);
          end
        end
      end
      KIND_SCALE: begin
        if (ra < nr) begin
          for (int i = 0; i < nc; i++) cells[ra*NCOL+i] = fx_product(cells[ra*NCOL+i], c.value);
        end
      end
      KIND_SORT: begin
        if (col < nc) begin
          for (int i = 1; i < nr; i++) begin
            k = i;
            while (k != 0 && cells[k*NCOL+col] > cells[(k-1)*NCOL+col]) begin
              swap_cells(k, k - 1, nc);
              k--;
            end
          end
        end
      end
      KIND_NORM: begin
        if (ra < nr) begin
          lead = 0;
          while (lead < nc && cells[ra*NCOL+lead] == 0) lead++;
          if (lead >= nc) begin
            r.status = STATUS_ZERO_ROW;
          end else begin
            piv = cells[ra*NCOL+lead];
            if (piv != (64'sd1 <<< FRAC)) begin
              for (int i = lead; i < nc; i++) begin
                num = cells[ra*NCOL+i];
                num = num <<< FRAC;
                cells[ra*NCOL+i] = sat_cell(num / piv);
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (r.status == STATUS_OK && clipped) r.status = STATUS_SAT;
    return r;
  endfunction

  function automatic int idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 5);
    return 0;
  endfunction

  // Present one command and hold it until its transfer; valid stays high
  // afterwards so a following command can be presented without a gap.
  task automatic send_cmd(input cmd_t c, input bit typed, input res_t typed_res);
    int   gap;
    res_t r;
    gap = idle_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk_i); while (!cmd_ready);
    r = apply_cmd(c);
    pending_res.insert(pending_res.size(), typed ? typed_res : r);
  endtask

  // Drop valid, wait for all results and let the engine settle.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One register write; valid drops before the next write.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = data;
    else rows_reg = rows_reg;
    if (idx == CFG_COLS) cols_reg = data;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return 32'sh0;
      3:       return 32'sh00010000;
      4:       return 32'sh7FFFFFFF;
      5:       return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  // Mostly in-range indexes so commands do work; some land out of range.
  function automatic logic [2:0] rand_index(input int lim);
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(0, lim - 1));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   w;
    int   nr;
    int   nc;
    nr = eff_dim(rows_reg, NROW);
    nc = eff_dim(cols_reg, NCOL);
    w = $urandom_range(0, 99);
    if (w < 25)      c.kind = KIND_WRITE;
    else if (w < 45) c.kind = KIND_READ;
    else if (w < 55) c.kind = KIND_SWAP;
    else if (w < 67) c.kind = KIND_ADD;
    else if (w < 77) c.kind = KIND_SCALE;
    else if (w < 85) c.kind = KIND_SORT;
    else if (w < 97) c.kind = KIND_NORM;
    else             c.kind = kind_e'(3'd7);
    c.row_a = rand_index(nr);
    c.row_b = rand_index(nr);
    c.column = rand_index(nc);
    c.value = rand_value();
    return c;
  endfunction

  // Result side stalls in random bursts while idle_on is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      res_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      ready_hold <= $urandom_range(0, 4);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid && res_ready) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: read_value=%h status=%0d",
                                       res.read_value, res.status);
      end else begin
        want = pending_res.pop_front();
        if (res.read_value !== want.read_value || res.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected read_value=%h status=%0d, got read_value=%h status=%0d",
                     want.read_value, want.status, res.read_value, res.status);
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random phases over several sizes.
  initial begin
    cmd_t          c;
    res_t          tr;
    logic [3:0]    phase_rows [9] = '{4'd8, 4'd1, 4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8};
    logic [3:0]    phase_cols [9] = '{4'd8, 4'd1, 4'd1, 4'd8, 4'd5, 4'd15, 4'd0, 4'd8, 4'd8};
    for (int r = 0; r < NROW; r++)
      for (int k = 0; k < NCOL; k++) cells[r*NCOL+k] = (r * k) << FRAC;
    rows_reg = DIM_RESET;
    cols_reg = DIM_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      c.kind = dir_tab[i].kind;
      c.row_a = dir_tab[i].ra;
      c.row_b = dir_tab[i].rb;
      c.column = dir_tab[i].col;
      c.value = dir_tab[i].val;
      tr.read_value = dir_tab[i].exp_rd;
      tr.status = dir_tab[i].exp_st;
      send_cmd(c, dir_tab[i].typed, tr);
    end
    drain();

    for (int p = 0; p < 9; p++) begin
      write_cfg(CFG_ROWS, phase_rows[p]);
      write_cfg(CFG_COLS, phase_cols[p]);
      if (p == 8) idle_on = 1'b0;
      for (int n = 0; n < 185; n++) send_cmd(rand_cmd(), 1'b0, '0);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mroe_pkg.sv
hdl/mroe_store.sv
hdl/mroe_div.sv
hdl/matrix_row_operation_engine.sv
test/matrix_row_operation_engine_test.sv
